// ===== rtl/core/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the signed decimal text formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned CharW      = 6;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned MaxDigits  = 10;
  localparam int unsigned PosW       = $clog2(MaxDigits);
  localparam int unsigned QueueDepth = 2;

  localparam logic [CharW-1:0]  AsciiZero  = 6'd48;
  localparam logic [CharW-1:0]  AsciiMinus = 6'd45;
  localparam logic [ValueW-1:0] Radix      = 32'd10;
  localparam logic [63:0]       Recip10    = 64'h0000_0000_CCCC_CCCD;
  localparam int unsigned       RecipShift = 35;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/itoa_front.sv =====
// ----------------------------------------------------------------------------
// itoa_front
// Accepts an item and splits it into a sign flag and an unsigned magnitude.
// ----------------------------------------------------------------------------
module itoa_front (
  input  logic                              start,
  input  itoa_pkg::q_status_t               q_status,
  input  logic signed [itoa_pkg::ValueW-1:0] value,
  output logic                              busy,
  output logic                              push,
  output itoa_pkg::item_t                   push_item
);

  logic [itoa_pkg::ValueW-1:0] raw;

  assign raw            = value;
  assign busy           = q_status.full;
  assign push           = start && !q_status.full;
  assign push_item.neg  = raw[itoa_pkg::ValueW-1];
  // The negation wraps the most negative value onto its true magnitude.
  assign push_item.mag  = raw[itoa_pkg::ValueW-1] ? (~raw + 1'b1) : raw;

endmodule

// ===== rtl/core/itoa_queue.sv =====
// ----------------------------------------------------------------------------
// itoa_queue
// Small first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module itoa_queue #(
  parameter int unsigned DEPTH = itoa_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  itoa_pkg::item_t     push_item,
  input  logic                pop,
  output itoa_pkg::item_t     pop_item,
  output itoa_pkg::q_status_t q_status
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  itoa_pkg::item_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign q_status.full  = (count == FullCnt);
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_item       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/itoa_back.sv =====
// ----------------------------------------------------------------------------
// itoa_back
// Extracts decimal digits one per cycle and emits the text one character
// per cycle, most significant first.
// ----------------------------------------------------------------------------
module itoa_back (
  input  logic                         clk,
  input  logic                         rst,
  input  itoa_pkg::q_status_t          q_status,
  input  itoa_pkg::item_t              pop_item,
  output logic                         pop,
  output logic                         strobe,
  output logic [itoa_pkg::CharW-1:0]   text_char,
  output logic                         last
);

  localparam logic [itoa_pkg::PosW-1:0] TopPos = itoa_pkg::PosW'(itoa_pkg::MaxDigits - 1);

  itoa_pkg::state_t              state;
  itoa_pkg::state_t              state_next;
  logic                          neg;
  logic [itoa_pkg::ValueW-1:0]   mag;
  logic [itoa_pkg::PosW-1:0]     pos;
  logic [itoa_pkg::DigitW-1:0]   digits [itoa_pkg::MaxDigits];

  logic [63:0]                   prod;
  logic [itoa_pkg::ValueW-1:0]   quot;
  logic [itoa_pkg::ValueW-1:0]   diff;
  logic [itoa_pkg::DigitW-1:0]   rem;
  logic                          div_done;

  logic                          strobe_next;
  logic [itoa_pkg::CharW-1:0]    text_char_next;
  logic                          last_next;

  assign prod     = {32'd0, mag} * itoa_pkg::Recip10;
  assign quot     = itoa_pkg::ValueW'(prod[63:itoa_pkg::RecipShift]);
  assign diff     = mag - ((quot << 3) + (quot << 1));
  assign rem      = diff[itoa_pkg::DigitW-1:0];
  assign div_done = (quot == '0) || (pos == TopPos);

  always_comb begin
    state_next = state;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        if (!q_status.empty) begin
          state_next = itoa_pkg::ST_DIVIDE;
        end
      end
      itoa_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_next = neg ? itoa_pkg::ST_SIGN : itoa_pkg::ST_EMIT;
        end
      end
      itoa_pkg::ST_SIGN: begin
        state_next = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (pos == '0) begin
          state_next = itoa_pkg::ST_IDLE;
        end
      end
      default: state_next = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop            = 1'b0;
    strobe_next    = 1'b0;
    text_char_next = itoa_pkg::AsciiZero;
    last_next      = 1'b0;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        pop = !q_status.empty;
      end
      itoa_pkg::ST_DIVIDE: begin
      end
      itoa_pkg::ST_SIGN: begin
        strobe_next    = 1'b1;
        text_char_next = itoa_pkg::AsciiMinus;
      end
      itoa_pkg::ST_EMIT: begin
        strobe_next    = 1'b1;
        text_char_next = itoa_pkg::AsciiZero + itoa_pkg::CharW'(digits[pos]);
        last_next      = (pos == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == itoa_pkg::ST_IDLE && pop) begin
      neg <= pop_item.neg;
      mag <= pop_item.mag;
    end else if (state == itoa_pkg::ST_DIVIDE) begin
      mag <= quot;
    end
    if (state == itoa_pkg::ST_DIVIDE) begin
      digits[pos] <= rem;
    end
    text_char <= text_char_next;
    last      <= last_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= itoa_pkg::ST_IDLE;
      pos    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      unique case (state)
        itoa_pkg::ST_IDLE:   pos <= '0;
        itoa_pkg::ST_DIVIDE: pos <= div_done ? pos : pos + 1'b1;
        itoa_pkg::ST_SIGN:   pos <= pos;
        itoa_pkg::ST_EMIT:   pos <= (pos == '0) ? pos : pos - 1'b1;
        default:             pos <= '0;
      endcase
    end
  end

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises only when
// the two-entry input queue is full. For each item the back end pops it from
// the queue, runs the divide-by-ten step once per decimal digit (a single
// constant multiplier), emits a minus sign if the value is negative, and then
// emits the digits, most significant first; it pops the next item only after
// the final character of the current one has been emitted. Each
// character appears for exactly one cycle with strobe high and must be
// captured then, since the receiver cannot hold results off; last marks the
// final character of each number.
module signed_int_to_decimal_ascii_unit #(
  parameter int unsigned QUEUE_DEPTH = itoa_pkg::QueueDepth
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [itoa_pkg::ValueW-1:0] value,
  output logic                               busy,
  output logic                               strobe,
  output logic [itoa_pkg::CharW-1:0]         text_char,
  output logic                               last
);

  itoa_pkg::q_status_t q_status;
  itoa_pkg::item_t     push_item;
  itoa_pkg::item_t     pop_item;
  logic                push;
  logic                pop;

  itoa_front u_front (
    .start     (start),
    .q_status  (q_status),
    .value     (value),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  itoa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  itoa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_item  (pop_item),
    .pop       (pop),
    .strobe    (strobe),
    .text_char (text_char),
    .last      (last)
  );

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (text_char == itoa_pkg::AsciiMinus) ||
               ((text_char >= itoa_pkg::AsciiZero) && (text_char <= 6'd57)))
    else $error("Character outside the legal set.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && text_char == itoa_pkg::AsciiMinus) |-> !last)
    else $error("Minus sign marked as the final character.");

  a_minus_then_digit: assert property (@(posedge clk) disable iff (rst)
    (strobe && text_char == itoa_pkg::AsciiMinus) |=>
      (strobe && text_char != itoa_pkg::AsciiMinus))
    else $error("Minus sign not followed at once by a digit.");

endmodule
